[design/hti_pkg.sv]
// Shared types, widths and constants of the tension/bias Hermite interpolator.
// No dependencies; every other design file imports this package.
package hti_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   localparam int Q14_BITS  = 16;
   localparam int Q14_ONE   = 16384;
   localparam int WT_W      = 17;
   localparam int WT_SHIFT  = 15;
   localparam int TAN_SHIFT = 10;
   localparam int TAN_FRAC  = 4;

   localparam int DIFF_W    = SAMPLE_BITS + 1;
   localparam int TPROD_W   = DIFF_W + WT_W;
   localparam int TSUM_W    = TPROD_W + 1;
   localparam int TAN_W     = TSUM_W - TAN_SHIFT;

   localparam int H_W       = FRAC_BITS + 4;
   localparam int HY_W      = H_W + SAMPLE_BITS;
   localparam int HM_W      = H_W + TAN_W;
   localparam int HYS_W     = HY_W + 1 + TAN_FRAC;
   localparam int HMS_W     = HM_W + 1;
   localparam int ACC_W     = ((HYS_W > HMS_W) ? HYS_W : HMS_W) + 1;
   localparam int ACC_SHIFT = FRAC_BITS + TAN_FRAC;
   localparam int RES_W     = ACC_W - ACC_SHIFT;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      REG_TENSION = 1'b0,
      REG_BIAS    = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic        [FRAC_BITS-1:0]   position_frac;
      logic signed [SAMPLE_BITS-1:0] sample_prev;
      logic signed [SAMPLE_BITS-1:0] sample_left;
      logic signed [SAMPLE_BITS-1:0] sample_right;
      logic signed [SAMPLE_BITS-1:0] sample_next;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] interpolated;
      logic                          clipped;
   } rsp_item_type;

   typedef struct packed {
      logic signed [WT_W-1:0] wa;
      logic signed [WT_W-1:0] wb;
   } weights_type;

   typedef struct packed {
      logic signed [H_W-1:0] h00;
      logic signed [H_W-1:0] h10;
      logic signed [H_W-1:0] h01;
      logic signed [H_W-1:0] h11;
   } basis_type;

   typedef struct packed {
      logic                          valid;
      logic signed [TAN_W-1:0]       m0;
      logic signed [TAN_W-1:0]       m1;
      logic signed [SAMPLE_BITS-1:0] y1;
      logic signed [SAMPLE_BITS-1:0] y2;
   } tangent_type;

endpackage

[design/hti_csr.sv]
// Register file for tension and bias, plus the registered Q14 tangent weights.
// Depends on hti_pkg.
module hti_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [hti_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [hti_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [hti_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output hti_pkg::weights_type               weights
);
   import hti_pkg::*;

   localparam logic signed [Q14_BITS-1:0] Q14_POS = Q14_BITS'(Q14_ONE);
   localparam logic signed [Q14_BITS-1:0] Q14_NEG = -Q14_POS;

   logic signed [Q14_BITS-1:0] tension_ff, tension_in;
   logic signed [Q14_BITS-1:0] bias_ff, bias_in;
   logic signed [Q14_BITS-1:0] tension_clamped, bias_clamped;
   logic                       wr_en;
   reg_index_type              acc_index;
   logic [WT_W-1:0]            pb, nb, pt;
   logic [2*WT_W-1:0]          wa_sum, wb_sum;
   weights_type                weights_ff, weights_in;

   function automatic logic signed [Q14_BITS-1:0] clamp_q14(
      input logic signed [Q14_BITS-1:0] v);
      logic signed [Q14_BITS-1:0] r;
      r = v;
      if (v < Q14_NEG) r = Q14_NEG;
      if (v > Q14_POS) r = Q14_POS;
      return r;
   endfunction

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite & pready;
   assign acc_index = reg_index_type'(paddr[CSR_ADDR_W-1]);

   always_comb begin
      tension_in = tension_ff;
      bias_in    = bias_ff;
      if (wr_en) begin
         case (acc_index)
            REG_TENSION: tension_in = pwdata[Q14_BITS-1:0];
            REG_BIAS:    bias_in    = pwdata[Q14_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (acc_index)
         REG_TENSION: prdata = CSR_DATA_W'(tension_ff);
         REG_BIAS:    prdata = CSR_DATA_W'(bias_ff);
         default:     prdata = '0;
      endcase
   end

   // weights follow the next register values, so they are current at the write edge
   assign tension_clamped = clamp_q14(tension_in);
   assign bias_clamped    = clamp_q14(bias_in);
   assign pb = WT_W'(Q14_ONE) + WT_W'(bias_clamped);
   assign nb = WT_W'(Q14_ONE) - WT_W'(bias_clamped);
   assign pt = WT_W'(Q14_ONE) - WT_W'(tension_clamped);
   assign wa_sum = pb * pt + (2*WT_W)'(2 ** (WT_SHIFT - 1));
   assign wb_sum = nb * pt + (2*WT_W)'(2 ** (WT_SHIFT - 1));
   assign weights_in.wa = wa_sum[WT_SHIFT +: WT_W];
   assign weights_in.wb = wb_sum[WT_SHIFT +: WT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= '0;
         bias_ff    <= '0;
         weights_ff.wa <= WT_W'((Q14_ONE * Q14_ONE) >> WT_SHIFT);
         weights_ff.wb <= WT_W'((Q14_ONE * Q14_ONE) >> WT_SHIFT);
      end else begin
         tension_ff <= tension_in;
         bias_ff    <= bias_in;
         weights_ff <= weights_in;
      end
   end

   assign weights = weights_ff;

endmodule

[design/hti_basis.sv]
// Three-stage pipeline that forms mu^2, mu^3 and the four cubic Hermite basis weights.
// Depends on hti_pkg.
module hti_basis (
   input  logic                              clock,
   input  logic [hti_pkg::FRAC_BITS-1:0]     mu,
   output hti_pkg::basis_type                basis
);
   import hti_pkg::*;

   localparam int F = FRAC_BITS;
   localparam logic signed [H_W-1:0] H_ONE = H_W'(2 ** F);

   logic [F-1:0]          mu_s1_ff, mu_s2_ff;
   logic [2*F-1:0]        mumu_ff, mumu_in;
   logic [2*F-1:0]        mu2_sum;
   logic [F-1:0]          mu2_s2_ff, mu2_in;
   logic [2*F-1:0]        mu3raw_ff, mu3raw_in;
   logic [2*F-1:0]        mu3_sum;
   logic signed [H_W-1:0] mu_h, mu2_h, mu3_h;
   basis_type             basis_ff, basis_in;

   assign mumu_in   = mu * mu;
   assign mu2_sum   = mumu_ff + (2*F)'(2 ** (F - 1));
   assign mu2_in    = mu2_sum[2*F-1:F];
   assign mu3raw_in = mu2_in * mu_s1_ff;

   assign mu3_sum = mu3raw_ff + (2*F)'(2 ** (F - 1));
   assign mu_h    = H_W'(mu_s2_ff);
   assign mu2_h   = H_W'(mu2_s2_ff);
   assign mu3_h   = H_W'(mu3_sum[2*F-1:F]);

   assign basis_in.h00 = (mu3_h <<< 1) - ((mu2_h <<< 1) + mu2_h) + H_ONE;
   assign basis_in.h10 = mu3_h - (mu2_h <<< 1) + mu_h;
   assign basis_in.h01 = mu3_h - mu2_h;
   assign basis_in.h11 = ((mu2_h <<< 1) + mu2_h) - (mu3_h <<< 1);

   always_ff @(posedge clock) begin
      mu_s1_ff  <= mu;
      mumu_ff   <= mumu_in;
      mu_s2_ff  <= mu_s1_ff;
      mu2_s2_ff <= mu2_in;
      mu3raw_ff <= mu3raw_in;
      basis_ff  <= basis_in;
   end

   assign basis = basis_ff;

endmodule

[design/hti_tangent.sv]
// Three-stage pipeline that forms the two tension/bias tangents in Q4 and carries valid.
// Depends on hti_pkg.
module hti_tangent (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  hti_pkg::req_item_type in_item,
   input  hti_pkg::weights_type  weights,
   output hti_pkg::tangent_type  tan_out
);
   import hti_pkg::*;

   logic                          v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0]      d0_ff, d1_ff, d2_ff;
   logic signed [SAMPLE_BITS-1:0] y1_s1_ff, y2_s1_ff, y1_s2_ff, y2_s2_ff;
   logic signed [TPROD_W-1:0]     p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [TPROD_W-1:0]     p0_in, p1_in, p2_in, p3_in;
   logic signed [TSUM_W-1:0]      sum0, sum1;
   tangent_type                   tan_ff, tan_in;

   assign p0_in = d0_ff * weights.wa;
   assign p1_in = d1_ff * weights.wb;
   assign p2_in = d1_ff * weights.wa;
   assign p3_in = d2_ff * weights.wb;

   assign sum0 = TSUM_W'(p0_ff) + TSUM_W'(p1_ff) + TSUM_W'(2 ** (TAN_SHIFT - 1));
   assign sum1 = TSUM_W'(p2_ff) + TSUM_W'(p3_ff) + TSUM_W'(2 ** (TAN_SHIFT - 1));

   assign tan_in.valid = v2_ff;
   assign tan_in.m0    = sum0[TSUM_W-1:TAN_SHIFT];
   assign tan_in.m1    = sum1[TSUM_W-1:TAN_SHIFT];
   assign tan_in.y1    = y1_s2_ff;
   assign tan_in.y2    = y2_s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= tan_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      d0_ff    <= DIFF_W'(in_item.sample_left)  - DIFF_W'(in_item.sample_prev);
      d1_ff    <= DIFF_W'(in_item.sample_right) - DIFF_W'(in_item.sample_left);
      d2_ff    <= DIFF_W'(in_item.sample_next)  - DIFF_W'(in_item.sample_right);
      y1_s1_ff <= in_item.sample_left;
      y2_s1_ff <= in_item.sample_right;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      p3_ff    <= p3_in;
      y1_s2_ff <= y1_s1_ff;
      y2_s2_ff <= y2_s1_ff;
      tan_ff   <= tan_in;
   end

   always_comb begin
      tan_out       = tan_ff;
      tan_out.valid = v3_ff;
   end

endmodule

[design/hti_blend.sv]
// Three-stage back end: basis products, partial sums, then rounding and saturation.
// Depends on hti_pkg.
module hti_blend (
   input  logic                  clock,
   input  logic                  reset,
   input  hti_pkg::tangent_type  tan_in,
   input  hti_pkg::basis_type    basis,
   output logic                  out_valid,
   output hti_pkg::rsp_item_type out_item
);
   import hti_pkg::*;

   localparam logic signed [RES_W-1:0] RES_MAX =
      {{(RES_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [RES_W-1:0] RES_MIN = ~RES_MAX;

   logic                      v4_ff, v5_ff, out_valid_ff;
   logic signed [HY_W-1:0]    hy0_ff, hy1_ff, hy0_in, hy1_in;
   logic signed [HM_W-1:0]    hm0_ff, hm1_ff, hm0_in, hm1_in;
   logic signed [HYS_W-1:0]   ys_ff, ys_in;
   logic signed [HMS_W-1:0]   ms_ff, ms_in;
   logic signed [ACC_W-1:0]   acc;
   logic signed [RES_W-1:0]   res;
   rsp_item_type              out_item_ff, out_item_in;

   assign hy0_in = basis.h00 * tan_in.y1;
   assign hy1_in = basis.h11 * tan_in.y2;
   assign hm0_in = basis.h10 * tan_in.m0;
   assign hm1_in = basis.h01 * tan_in.m1;

   assign ys_in = (HYS_W'(hy0_ff) + HYS_W'(hy1_ff)) <<< TAN_FRAC;
   assign ms_in = HMS_W'(hm0_ff) + HMS_W'(hm1_ff);

   assign acc = ACC_W'(ys_ff) + ACC_W'(ms_ff) + ACC_W'(2 ** (ACC_SHIFT - 1));
   assign res = acc[ACC_W-1:ACC_SHIFT];

   always_comb begin
      out_item_in.interpolated = res[SAMPLE_BITS-1:0];
      out_item_in.clipped      = 1'b0;
      if (res > RES_MAX) begin
         out_item_in.interpolated = RES_MAX[SAMPLE_BITS-1:0];
         out_item_in.clipped      = 1'b1;
      end
      if (res < RES_MIN) begin
         out_item_in.interpolated = RES_MIN[SAMPLE_BITS-1:0];
         out_item_in.clipped      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v4_ff        <= tan_in.valid;
         v5_ff        <= v4_ff;
         out_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      hy0_ff      <= hy0_in;
      hy1_ff      <= hy1_in;
      hm0_ff      <= hm0_in;
      hm1_ff      <= hm1_in;
      ys_ff       <= ys_in;
      ms_ff       <= ms_in;
      out_item_ff <= out_item_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

[design/hermite_tension_bias_interpolator.sv]
// Top level of the tension/bias cubic Hermite interpolator.
// Depends on hti_pkg, hti_csr, hti_basis, hti_tangent and hti_blend.
//
//   channel   handshake                       payload
//   request   start, busy                     req_item (hti_pkg::req_item_type)
//   response  rsp_strobe                      rsp_item (hti_pkg::rsp_item_type)
//   config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// Three stages form the tangents and basis weights, then products, partial sums
// and round/saturate. One transaction is taken every cycle while busy is low.
// Reset is synchronous; busy is high only while reset is asserted.
// The result is shown for one cycle and the receiver cannot stall it.
module hermite_tension_bias_interpolator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  hti_pkg::req_item_type              req_item,
   output logic                               rsp_strobe,
   output hti_pkg::rsp_item_type              rsp_item,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [hti_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [hti_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [hti_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import hti_pkg::*;

   localparam int PIPE_DEPTH = 6;

   logic        accept;
   weights_type weights;
   basis_type   basis;
   tangent_type tangents;

   assign busy   = reset;
   assign accept = start & ~busy;

   hti_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .weights (weights)
   );

   hti_basis u_basis (
      .clock (clock),
      .mu    (req_item.position_frac),
      .basis (basis)
   );

   hti_tangent u_tangent (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_item  (req_item),
      .weights  (weights),
      .tan_out  (tangents)
   );

   hti_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .tan_in    (tangents),
      .basis     (basis),
      .out_valid (rsp_strobe),
      .out_item  (rsp_item)
   );

   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PIPE_DEPTH))
      else $error("result strobe without a matching accepted transaction");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_DEPTH rsp_strobe)
      else $error("accepted transaction produced no result");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.clipped) |->
         (rsp_item.interpolated == {1'b0, {(SAMPLE_BITS - 1){1'b1}}} ||
          rsp_item.interpolated == {1'b1, {(SAMPLE_BITS - 1){1'b0}}}))
      else $error("clipped result not at a range limit");

endmodule
